FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge while out of reset.
`define DTBR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check on every rising edge, reset included.
`define DTBR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/dtbr_pkg.sv
// ----------------------------------------------------------------------------
// dtbr_pkg
// Shared constants and types of the decimal text to BCD real converter.
// ----------------------------------------------------------------------------
package dtbr_pkg;

    // Digits in the packed result; one more is kept for rounding.
    localparam int KEPT_DIGITS = 14;
    localparam int STORE_DEPTH = KEPT_DIGITS + 1;
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int SHIFT_W     = 8;
    localparam int EXPV_W      = 7;
    localparam int ESUM_W      = 10;

    localparam int EXP_BIAS  = 64;
    localparam int EXP_LIMIT = 63;
    localparam int EXP_SAT   = 127;
    localparam int ROUND_MIN = 5;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_E_UP  = 8'h45;
    localparam logic [7:0] CH_E_LO  = 8'h65;
    localparam logic [7:0] CH_D_UP  = 8'h44;
    localparam logic [7:0] CH_D_LO  = 8'h64;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_POINT   = 2'd1,
        STAT_EXP_OVF = 2'd2
    } status_t;

    // Parsed number as handed from the parser to the rounding logic.
    typedef struct packed {
        logic                                neg;
        logic                                syn_err;
        logic                                lead_zero;
        logic [STORE_DEPTH-1:0][3:0]         digits;
        logic signed [SHIFT_W-1:0]           shift;
        logic [EXPV_W-1:0]                   exp_val;
        logic                                exp_neg;
    } dtbr_snap_t;

    localparam dtbr_snap_t SNAP_INIT = '{
        neg:       1'b0,
        syn_err:   1'b0,
        lead_zero: 1'b1,
        digits:    '0,
        shift:     '0,
        exp_val:   '0,
        exp_neg:   1'b0
    };

endpackage

FILE: hdl/decimal_text_to_bcd_real.sv
// ----------------------------------------------------------------------------
// decimal_text_to_bcd_real
// Reads decimal number text one character a beat and emits an 8-byte BCD
// real with status on the beat that ends the text.
//
//   channel  | direction | tdata                  | tuser    | tlast
//   s_axis   | in        | [7:0] character        | -        | last_char
//   m_axis   | out       | [63:0] encoded_value   | [1:0] st | -
//
// One character is accepted every cycle while the result side keeps up.
// A result passes through the parser snapshot register and, after rounding,
// the output register. Characters other than the last produce no result
// beat. rst_n clears the parser state and both valid flags at once.
// A stall on m_axis holds the output register; the snapshot register then
// fills and s_axis stalls once it is full.
// ----------------------------------------------------------------------------
module decimal_text_to_bcd_real
    import dtbr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] character
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] encoded_value
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    dtbr_snap_t  snap;
    logic        snap_valid;
    logic        out_free;
    logic        take;
    logic        beat;
    logic [63:0] value;
    status_t     status;

    logic        out_valid_reg;
    logic [63:0] out_data_reg;
    status_t     out_user_reg;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign take          = snap_valid && out_free;
    assign s_axis_tready = !snap_valid || out_free;
    assign beat          = s_axis_tvalid && s_axis_tready;

    dtbr_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat       (beat),
        .ch         (s_axis_tdata),
        .last       (s_axis_tlast),
        .take       (take),
        .snap       (snap),
        .snap_valid (snap_valid)
    );

    dtbr_round u_round (
        .snap   (snap),
        .value  (value),
        .status (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (take)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg <= value;
            out_user_reg <= status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

FILE: hdl/dtbr_parse.sv
// ----------------------------------------------------------------------------
// dtbr_parse
// Character parser: mantissa digits, point, exponent; hands the parsed number
// to a snapshot register on the last character of the text.
// ----------------------------------------------------------------------------
module dtbr_parse
    import dtbr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       beat,
    input  logic [7:0] ch,
    input  logic       last,
    input  logic       take,
    output dtbr_snap_t snap,
    output logic       snap_valid
);

    typedef enum logic [2:0] {
        PH_SIGN,
        PH_MANT,
        PH_ESIGN,
        PH_EDIG,
        PH_STOP
    } phase_t;

    localparam int EXPS_W = 10;
    localparam logic signed [SHIFT_W-1:0] SHIFT_MAX = {1'b0, {(SHIFT_W-1){1'b1}}};
    localparam logic signed [SHIFT_W-1:0] SHIFT_MIN = {1'b1, {(SHIFT_W-1){1'b0}}};

    phase_t           phase_reg, phase_next;
    logic             point_reg, point_next;
    logic [CNT_W-1:0] count_reg, count_next;
    dtbr_snap_t       num_reg, num_next;
    dtbr_snap_t       snap_reg;
    logic             snap_valid_reg;

    logic              is_dig;
    logic [3:0]        dval;
    logic              is_exp_mark;
    logic              do_mant;
    logic              do_exp;
    logic [EXPS_W-1:0] exp_sum;

    assign is_dig      = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign dval        = ch[3:0];
    assign is_exp_mark = (ch == CH_E_UP) || (ch == CH_E_LO) ||
                         (ch == CH_D_UP) || (ch == CH_D_LO);
    assign exp_sum     = {{(EXPS_W-EXPV_W){1'b0}}, num_reg.exp_val} * EXPS_W'(10)
                         + {{(EXPS_W-4){1'b0}}, dval};

    always_comb
    begin
        phase_next = phase_reg;
        point_next = point_reg;
        count_next = count_reg;
        num_next   = num_reg;
        do_mant    = 1'b0;
        do_exp     = 1'b0;

        case (phase_reg)
            PH_SIGN:
            begin
                phase_next = PH_MANT;
                if (ch == CH_MINUS)
                    num_next.neg = 1'b1;
                else
                    do_mant = 1'b1;
            end
            PH_MANT:
                do_mant = 1'b1;
            PH_ESIGN:
            begin
                phase_next = PH_EDIG;
                if (ch == CH_MINUS)
                    num_next.exp_neg = 1'b1;
                else if (ch != CH_PLUS)
                    do_exp = 1'b1;
            end
            PH_EDIG:
                do_exp = 1'b1;
            default:
                ;
        endcase

        if (do_mant)
        begin
            if (is_dig)
            begin
                if (num_reg.lead_zero && (dval == 4'd0))
                begin
                    // leading zero: dropped; after the point it also lowers the shift
                    if (point_reg && (num_reg.shift != SHIFT_MIN))
                        num_next.shift = num_reg.shift - SHIFT_W'(1);
                end
                else
                begin
                    num_next.lead_zero = 1'b0;
                    if (count_reg < CNT_W'(STORE_DEPTH))
                    begin
                        for (int i = 0; i < STORE_DEPTH; i++)
                            if (count_reg == CNT_W'(i))
                                num_next.digits[i] = dval;
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (!point_reg && (num_reg.shift != SHIFT_MAX))
                        num_next.shift = num_reg.shift + SHIFT_W'(1);
                end
            end
            else if (ch == CH_POINT)
            begin
                if (point_reg)
                begin
                    num_next.syn_err = 1'b1;
                    phase_next       = PH_STOP;
                end
                else
                    point_next = 1'b1;
            end
            else if (is_exp_mark)
                phase_next = PH_ESIGN;
            else
                phase_next = PH_STOP;
        end

        if (do_exp)
        begin
            if (!is_dig)
                phase_next = PH_STOP;
            else if (exp_sum > EXPS_W'(EXP_LIMIT))
            begin
                // stop collecting and saturate
                num_next.exp_val = (exp_sum > EXPS_W'(EXP_SAT)) ? EXPV_W'(EXP_SAT)
                                                                 : exp_sum[EXPV_W-1:0];
                phase_next       = PH_STOP;
            end
            else
                num_next.exp_val = exp_sum[EXPV_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SIGN;
            point_reg      <= 1'b0;
            count_reg      <= '0;
            num_reg        <= SNAP_INIT;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            if (beat && last)
                snap_valid_reg <= 1'b1;
            else if (take)
                snap_valid_reg <= 1'b0;
            if (beat)
            begin
                if (last)
                begin
                    // text complete: start the next number from scratch
                    phase_reg <= PH_SIGN;
                    point_reg <= 1'b0;
                    count_reg <= '0;
                    num_reg   <= SNAP_INIT;
                end
                else
                begin
                    phase_reg <= phase_next;
                    point_reg <= point_next;
                    count_reg <= count_next;
                    num_reg   <= num_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat && last)
            snap_reg <= num_next;
    end

    assign snap       = snap_reg;
    assign snap_valid = snap_valid_reg;

endmodule

FILE: hdl/dtbr_round.sv
// ----------------------------------------------------------------------------
// dtbr_round
// Rounds the parsed digits half up and packs sign, excess-64 exponent and
// BCD digits into the 8-byte result, with status.
// ----------------------------------------------------------------------------
module dtbr_round
    import dtbr_pkg::*;
(
    input  dtbr_snap_t  snap,
    output logic [63:0] value,
    output status_t     status
);

    localparam logic signed [ESUM_W-1:0] E_MAX  = ESUM_W'(EXP_LIMIT);
    localparam logic signed [ESUM_W-1:0] E_MIN  = -ESUM_W'(EXP_BIAS);
    localparam logic signed [ESUM_W-1:0] E_BIAS = ESUM_W'(EXP_BIAS);

    logic [KEPT_DIGITS-1:0]      nine;
    logic [KEPT_DIGITS-1:0]      carry;
    logic [KEPT_DIGITS-1:0][3:0] rd;
    logic                        round_up;
    logic                        top_carry;
    logic signed [ESUM_W-1:0]    shift_x;
    logic signed [ESUM_W-1:0]    exp_x;
    logic signed [ESUM_W-1:0]    e_sum;
    logic signed [ESUM_W-1:0]    e_fin;
    logic signed [ESUM_W-1:0]    e_biased;
    logic [55:0]                 mant;

    assign round_up = snap.digits[KEPT_DIGITS] >= 4'(ROUND_MIN);

    always_comb
    begin
        logic c;
        c = 1'b0;
        for (int i = 0; i < KEPT_DIGITS; i++)
            nine[i] = (snap.digits[i] == 4'd9);
        // a digit takes the carry when every digit below it is a nine
        for (int i = 0; i < KEPT_DIGITS; i++)
        begin
            c = round_up;
            for (int j = 0; j < KEPT_DIGITS; j++)
                if (j > i)
                    c = c & nine[j];
            carry[i] = c;
        end
        top_carry = carry[0] & nine[0];
        for (int i = 0; i < KEPT_DIGITS; i++)
        begin
            if (!carry[i])
                rd[i] = snap.digits[i];
            else if (nine[i])
                rd[i] = 4'd0;
            else
                rd[i] = snap.digits[i] + 4'd1;
        end
        if (top_carry)
            rd[0] = 4'd1;
    end

    assign shift_x = {{(ESUM_W-SHIFT_W){snap.shift[SHIFT_W-1]}}, snap.shift};
    assign exp_x   = {{(ESUM_W-EXPV_W){1'b0}}, snap.exp_val};
    assign e_sum   = snap.exp_neg ? (shift_x - exp_x) : (shift_x + exp_x);
    assign e_fin   = e_sum + {{(ESUM_W-1){1'b0}}, top_carry};
    assign e_biased = e_fin + E_BIAS;

    always_comb
    begin
        mant = '0;
        for (int i = 0; i < KEPT_DIGITS; i++)
            mant[55-4*i -: 4] = rd[i];
    end

    always_comb
    begin
        value  = '0;
        status = STAT_OK;
        if (snap.syn_err)
            status = STAT_POINT;
        else if (snap.lead_zero)
            status = STAT_OK;
        else if (e_fin > E_MAX)
            status = STAT_EXP_OVF;
        else if (e_fin > E_MIN)
            value = {snap.neg, e_biased[6:0], mant};
    end

endmodule

FILE: hdl/dtbr_checker.sv
// ----------------------------------------------------------------------------
// dtbr_checker
// Port-level checks on the converter's result channel, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dtbr_checker
    import dtbr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    `DTBR_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result beat changed while stalled")

    `DTBR_ASSERT(a_err_zero, m_axis_tvalid && (m_axis_tuser != STAT_OK) |-> (m_axis_tdata == 64'd0), "error result carries a nonzero value")

    `DTBR_ASSERT(a_status_code, m_axis_tvalid |-> (m_axis_tuser == STAT_OK) || (m_axis_tuser == STAT_POINT) || (m_axis_tuser == STAT_EXP_OVF), "undefined status code")

    `DTBR_ASSERT(a_normalised, m_axis_tvalid && (m_axis_tdata != 64'd0) |-> (m_axis_tdata[55:52] != 4'd0) && (m_axis_tdata[62:56] != 7'd0), "nonzero result not normalised")

    `DTBR_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> !m_axis_tvalid, "result valid during reset")

endmodule

bind decimal_text_to_bcd_real dtbr_checker u_dtbr_checker (.*);

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for decimal_text_to_bcd_real. Number texts are sent
// one character a beat. A model of the parser tracks each accepted
// character, and on the last one it rounds and packs the expected 8-byte
// BCD real and status. Result beats are checked in order against it.
// The texts are directed cases first: grammar, errors, rounding, range and
// point saturation. Random texts follow, most well formed, the rest broken
// or noise, under several patterns of source idling and sink stalling.
// ----------------------------------------------------------------------------
module tb;
    import dtbr_pkg::*;

    typedef logic [7:0] char_q_t[$];

    typedef enum logic [2:0] {
        TXT_SIGN,
        TXT_MANT,
        TXT_EXP_SIGN,
        TXT_EXP_DIG,
        TXT_STOP
    } text_phase_t;

    typedef struct {
        logic [63:0] value;
        status_t     status;
    } bcd_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    // model of the parser state
    text_phase_t txt_phase;
    logic        neg_sign;
    logic        point_taken;
    logic        in_lead_zeros;
    logic [3:0]  mant_digits[STORE_DEPTH];
    int          mant_count;
    int          point_offset;
    int          exp_magnitude;
    logic        exp_is_neg;
    logic        two_points;

    bcd_result_t bcd_expected_q[$];
    bcd_result_t want_result;
    int          error_count = 0;
    int          chars_sent;
    int          send_idle_pct;
    int          recv_stall_pct;

    decimal_text_to_bcd_real i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("** decimal_text_to_bcd_real: FAILED **");
        $finish;
    end

    function automatic void clear_parser();
        txt_phase     = TXT_SIGN;
        neg_sign      = 1'b0;
        point_taken   = 1'b0;
        in_lead_zeros = 1'b1;
        foreach (mant_digits[i])
            mant_digits[i] = 4'd0;
        mant_count    = 0;
        point_offset  = 0;
        exp_magnitude = 0;
        exp_is_neg    = 1'b0;
        two_points    = 1'b0;
    endfunction

    // the point offset saturates to a signed byte
    function automatic void move_point(input int delta);
        int v;
        v = point_offset + delta;
        if (v > 127)
            v = 127;
        if (v < -128)
            v = -128;
        point_offset = v;
    endfunction

    function automatic void take_mantissa_char(input logic [7:0] ch);
        logic [3:0] dig;
        dig = ch[3:0];
        if (ch >= CH_ZERO && ch <= CH_NINE)
        begin
            if (in_lead_zeros && dig == 4'd0)
            begin
                // a zero ahead of the first significant digit; after the point it moves the point
                if (point_taken)
                    move_point(-1);
            end
            else
            begin
                in_lead_zeros = 1'b0;
                if (mant_count < STORE_DEPTH)
                begin
                    mant_digits[mant_count] = dig;
                    mant_count++;
                end
                if (!point_taken)
                    move_point(1);
            end
        end
        else if (ch == CH_POINT)
        begin
            if (point_taken)
            begin
                two_points = 1'b1;
                txt_phase  = TXT_STOP;
            end
            else
                point_taken = 1'b1;
        end
        else if (ch == CH_E_UP || ch == CH_E_LO || ch == CH_D_UP || ch == CH_D_LO)
            txt_phase = TXT_EXP_SIGN;
        else
            txt_phase = TXT_STOP;
    endfunction

    function automatic void take_exp_digit(input logic [7:0] ch);
        if (!(ch >= CH_ZERO && ch <= CH_NINE))
            txt_phase = TXT_STOP;
        else
        begin
            exp_magnitude = exp_magnitude * 10 + int'(ch[3:0]);
            if (exp_magnitude > EXP_LIMIT)
            begin
                if (exp_magnitude > EXP_SAT)
                    exp_magnitude = EXP_SAT;
                txt_phase = TXT_STOP;
            end
        end
    endfunction

    function automatic void advance_parser(input logic [7:0] ch);
        case (txt_phase)
            TXT_SIGN:
            begin
                txt_phase = TXT_MANT;
                if (ch == CH_MINUS)
                    neg_sign = 1'b1;
                else
                    take_mantissa_char(ch);
            end
            TXT_MANT:
                take_mantissa_char(ch);
            TXT_EXP_SIGN:
            begin
                txt_phase = TXT_EXP_DIG;
                if (ch == CH_MINUS)
                    exp_is_neg = 1'b1;
                else if (ch != CH_PLUS)
                    take_exp_digit(ch);
            end
            TXT_EXP_DIG:
                take_exp_digit(ch);
            default:
                ;
        endcase
    endfunction

    function automatic bcd_result_t round_and_pack();
        bcd_result_t r;
        logic [3:0]  d[STORE_DEPTH];
        int          e;
        logic        carry;
        r.value  = '0;
        r.status = STAT_OK;
        if (two_points)
            r.status = STAT_POINT;
        else if (!in_lead_zeros)
        begin
            d = mant_digits;
            e = point_offset + (exp_is_neg ? -exp_magnitude : exp_magnitude);
            if (d[KEPT_DIGITS] >= ROUND_MIN)
            begin
                carry = 1'b1;
                for (int i = KEPT_DIGITS - 1; i >= 0 && carry; i--)
                begin
                    if (d[i] == 4'd9)
                        d[i] = 4'd0;
                    else
                    begin
                        d[i]++;
                        carry = 1'b0;
                    end
                end
                // all nines: mantissa becomes 1000... one decade up
                if (carry)
                begin
                    d[0] = 4'd1;
                    e++;
                end
            end
            if (e > EXP_LIMIT)
                r.status = STAT_EXP_OVF;
            else if (e > -EXP_BIAS)
            begin
                r.value[63]    = neg_sign;
                r.value[62:56] = 7'(EXP_BIAS + e);
                for (int i = 0; i < KEPT_DIGITS; i++)
                    r.value[55 - 4 * i -: 4] = d[i];
            end
        end
        return r;
    endfunction

    task automatic send_char(input logic [7:0] ch, input logic last);
        @(negedge clk);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        chars_sent++;
        advance_parser(ch);
        if (last)
        begin
            bcd_expected_q.push_back(round_and_pack());
            clear_parser();
        end
    endtask

    task automatic send_text(input char_q_t txt);
        foreach (txt[i])
            send_char(txt[i], i == txt.size() - 1);
    endtask

    function automatic char_q_t to_chars(input string s);
        char_q_t q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        return q;
    endfunction

    // mode 1 leans to nines for carries, mode 2 to zeros
    function automatic logic [7:0] random_digit(input int mode);
        if (mode == 1 && $urandom_range(0, 9) != 0)
            return CH_NINE;
        if (mode == 2 && $urandom_range(0, 1) != 0)
            return CH_ZERO;
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic char_q_t random_text();
        char_q_t q;
        int      kind;
        int      mode;
        int      n;
        kind = $urandom_range(0, 99);
        if (kind < 15)
        begin
            n = $urandom_range(1, 6);
            repeat (n)
                q.push_back(8'($urandom_range(0, 255)));
            return q;
        end
        mode = $urandom_range(0, 3);
        if ($urandom_range(0, 2) == 0)
            q.push_back(CH_MINUS);
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 5);
        repeat (n)
            q.push_back(random_digit(mode));
        if ($urandom_range(0, 1) != 0)
        begin
            q.push_back(CH_POINT);
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 8))
                    q.push_back(CH_ZERO);
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 6);
            repeat (n)
                q.push_back(random_digit(mode));
        end
        if ($urandom_range(0, 2) == 0)
        begin
            case ($urandom_range(0, 3))
                0: q.push_back(CH_E_UP);
                1: q.push_back(CH_E_LO);
                2: q.push_back(CH_D_UP);
                default: q.push_back(CH_D_LO);
            endcase
            case ($urandom_range(0, 2))
                0: q.push_back(CH_PLUS);
                1: q.push_back(CH_MINUS);
                default: ;
            endcase
            repeat ($urandom_range(0, 3))
                q.push_back(random_digit(0));
        end
        if (q.size() == 0)
            q.push_back(random_digit(mode));
        // break the text: a second point or a stray byte somewhere
        if (kind >= 85)
            q.insert($urandom_range(0, q.size()),
                     ($urandom_range(0, 1) != 0) ? CH_POINT : 8'($urandom_range(0, 255)));
        else if (kind >= 80)
            q.push_back(8'($urandom_range(0, 255)));
        return q;
    endfunction

    always @(negedge clk)
        m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (bcd_expected_q.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result beat: value %h status %0d",
                             m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                want_result = bcd_expected_q.pop_front();
                if (m_axis_tdata !== want_result.value || m_axis_tuser !== want_result.status)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch: expected value %h status %0d, got value %h status %0d",
                                 want_result.value, want_result.status,
                                 m_axis_tdata, m_axis_tuser);
                end
            end
        end
    end

    task automatic test_grammar_and_errors();
        send_text(to_chars("0"));
        send_text(to_chars("-0"));
        send_text(to_chars("7"));
        send_text(to_chars("-123.456"));
        send_text(to_chars("000.000123"));
        send_text(to_chars(".5"));
        send_text(to_chars("-."));
        send_text(to_chars("1.2.3"));
        send_text(to_chars("12a34"));
        send_text(to_chars("+5"));
        send_text(to_chars("E5"));
        send_text(to_chars("1E5"));
        send_text(to_chars("-1e-5"));
        send_text(to_chars("2.5D+10"));
        send_text(to_chars("3d9x9"));
        send_text({8'hFF, CH_ZERO, 8'h00});
    endtask

    task automatic test_rounding_and_range();
        send_text(to_chars("3d63"));
        send_text(to_chars("1E63"));
        send_text(to_chars("0.5E64"));
        send_text(to_chars("-1E999"));
        send_text(to_chars("0.00E99"));
        send_text(to_chars("1E-64"));
        send_text(to_chars("1E-65"));
        send_text(to_chars("-99999999999999999"));
        send_text(to_chars("0.999999999999999E63"));
        send_text(to_chars("12345678901234549"));
        send_text(to_chars("123456789012345650"));
    endtask

    // push the point offset past both ends of its range
    task automatic test_point_saturation();
        char_q_t big;
        char_q_t tiny;
        big.push_back(CH_ZERO + 8'd1);
        repeat (135)
            big.push_back(CH_ZERO);
        tiny = {CH_ZERO, CH_POINT};
        repeat (135)
            tiny.push_back(CH_ZERO);
        tiny.push_back(CH_ZERO + 8'd4);
        send_text(big);
        send_text({big, to_chars("E-70")});
        send_text(tiny);
        send_text({tiny, to_chars("E+99")});
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int char_budget);
        int stop_at;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at        = chars_sent + char_budget;
        while (chars_sent < stop_at)
            send_text(random_text());
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = 8'h00;
        s_axis_tlast   = 1'b0;
        chars_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        clear_parser();
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_grammar_and_errors();
        test_rounding_and_range();
        test_point_saturation();
        test_random_traffic(0, 0, 295);
        test_random_traffic(47, 0, 295);
        test_random_traffic(0, 47, 295);
        test_random_traffic(9, 9, 295);

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait (bcd_expected_q.size() == 0);
        // allow any stray beat to show up
        repeat (10)
            @(posedge clk);
        if (error_count == 0)
            $display("** decimal_text_to_bcd_real: PASSED **");
        else
            $display("** decimal_text_to_bcd_real: FAILED **");
        $finish;
    end

endmodule

FILE: decimal_text_to_bcd_real.f
+incdir+hdl
hdl/dtbr_pkg.sv
hdl/dtbr_parse.sv
hdl/dtbr_round.sv
hdl/decimal_text_to_bcd_real.sv
hdl/dtbr_checker.sv
tb/tb.sv
